// ----- sv/simon_pkg.sv -----
`timescale 1ns / 1ps

package simon_pkg;

    localparam int WORD_BITS  = 64;
    localparam int ROUNDS     = 68;
    localparam int Z2_LEN     = 62;
    localparam int RND_BITS   = 7;
    localparam int ZIDX_BITS  = 6;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [WORD_BITS-1:0] Z2_SEQ   = 64'h3369_F885_192C_0EF5;
    localparam logic [WORD_BITS-1:0] KS_CONST = 64'hFFFF_FFFF_FFFF_FFFC;

    localparam logic [RND_BITS-1:0] ROUNDS_MAX = RND_BITS'(ROUNDS);
    localparam logic [RND_BITS-1:0] ROUND_LAST = RND_BITS'(ROUNDS - 1);
    localparam logic [RND_BITS-1:0] Z2_WRAP    = RND_BITS'(Z2_LEN);

    // register index codes
    localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_LOW     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_HIGH    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROUND_COUNT = 2'd2;

    typedef logic [WORD_BITS-1:0] word_t;

    function automatic word_t rotl(input word_t v, input int n);
        rotl = (v << n) | (v >> (WORD_BITS - n));
    endfunction

    function automatic word_t rotr(input word_t v, input int n);
        rotr = (v >> n) | (v << (WORD_BITS - n));
    endfunction

    // Feistel round function
    function automatic word_t simon_f(input word_t v);
        simon_f = (rotl(v, 1) & rotl(v, 8)) ^ rotl(v, 2);
    endfunction

endpackage

// ----- sv/simon_128_128_encrypt_top.sv -----
`timescale 1ns / 1ps

// SIMON 128/128 ECB encryption core, one Feistel round per clock.
// Input channel (in_valid/in_ready) carries a plaintext request as plain_y,
// plain_x; output channel (out_valid/out_ready) returns cipher_y, cipher_x.
// Configuration: cfg_write with cfg_index 0/1 loads key word low/high,
// index 2 loads round_count (7 bits, values above 68 behave as 68).
// Every key write starts a key schedule run, one round key per cycle
// into the on-chip key store; in_ready stays low meanwhile. A newer
// key write during the run restarts it with the updated key.
// Reset: key words clear to zero, round_count to 68, and the schedule runs
// for the all-zero key, so in_ready rises once that run is complete.
// A request accepted with r effective rounds runs its rounds in ST_RUN,
// then moves to the output register; one request is in flight at a time,
// and the core passes back through idle before the next one is taken,
// set by the single shared round unit and one key store read per round.
// The finished block moves into an output register, so the core returns
// to idle and takes the next request while the result waits. If the
// receiver stalls and the output register is still full when the next
// block completes, that block is held in the round registers until taken.
module simon_128_128_encrypt_top
    import simon_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [WORD_BITS-1:0]    cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [WORD_BITS-1:0]    plain_y,
    input  logic [WORD_BITS-1:0]    plain_x,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [WORD_BITS-1:0]    cipher_y,
    output logic [WORD_BITS-1:0]    cipher_x
);

    typedef enum logic [1:0] {
        ST_EXPAND,
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                state_reg, state_next;

    word_t                 key_low_reg, key_low_next;
    word_t                 key_high_reg, key_high_next;
    logic [RND_BITS-1:0]   round_count_reg, round_count_next;

    // key schedule working words and step counter
    word_t                 ka_reg, ka_next;
    word_t                 kb_reg, kb_next;
    logic [RND_BITS-1:0]   kidx_reg, kidx_next;

    // round datapath
    word_t                 y_reg, y_next;
    word_t                 x_reg, x_next;
    logic [RND_BITS-1:0]   rnd_reg, rnd_next;
    logic [RND_BITS-1:0]   lim_reg, lim_next;

    logic                  out_valid_reg, out_valid_next;
    word_t                 out_y_reg, out_y_next;
    word_t                 out_x_reg, out_x_next;

    // key store: one write port, one registered read port
    word_t                 key_mem [ROUNDS];
    word_t                 rk_q;
    logic [RND_BITS-1:0]   rk_addr;
    logic                  ks_we;

    logic                  key_write;
    logic                  accept;
    logic [RND_BITS-1:0]   zpos;
    logic                  zbit;
    word_t                 ks_t;
    word_t                 ks_new;

    assign key_write = cfg_write &&
                       (cfg_index == CFG_KEY_LOW || cfg_index == CFG_KEY_HIGH);
    // a key write in the same cycle holds off the request
    assign in_ready  = (state_reg == ST_IDLE) && !key_write;
    assign accept    = in_valid && in_ready;

    assign out_valid = out_valid_reg;
    assign cipher_y  = out_y_reg;
    assign cipher_x  = out_x_reg;

    // z2 bit for step kidx: position modulo 62, steps never exceed 67
    assign zpos   = (kidx_reg >= Z2_WRAP) ? (kidx_reg - Z2_WRAP) : kidx_reg;
    assign zbit   = Z2_SEQ[zpos[ZIDX_BITS-1:0]];
    assign ks_t   = rotr(kb_reg, 3);
    assign ks_new = ks_t ^ rotr(ks_t, 1) ^ ka_reg ^ KS_CONST ^ {{(WORD_BITS-1){1'b0}}, zbit};

    assign ks_we  = (state_reg == ST_EXPAND);

    always_comb
    begin
        key_low_next     = key_low_reg;
        key_high_next    = key_high_reg;
        round_count_next = round_count_reg;
        ka_next          = ka_reg;
        kb_next          = kb_reg;
        kidx_next        = kidx_reg;
        y_next           = y_reg;
        x_next           = x_reg;
        rnd_next         = rnd_reg;
        lim_next         = lim_reg;
        out_valid_next   = out_valid_reg;
        out_y_next       = out_y_reg;
        out_x_next       = out_x_reg;
        state_next       = state_reg;
        rk_addr          = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_EXPAND:
            begin
                ka_next   = kb_reg;
                kb_next   = ks_new;
                kidx_next = kidx_reg + 1'b1;
                if (kidx_reg == ROUND_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                rk_addr = '0;
                if (accept)
                begin
                    y_next     = plain_y;
                    x_next     = plain_x;
                    rnd_next   = '0;
                    lim_next   = (round_count_reg > ROUNDS_MAX) ? ROUNDS_MAX
                                                                : round_count_reg;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (rnd_reg != lim_reg)
                begin
                    // rk_q holds the key for round rnd_reg; fetch the next one
                    rk_addr  = (rnd_reg == ROUND_LAST) ? '0 : rnd_reg + 1'b1;
                    y_next   = x_reg;
                    x_next   = simon_f(x_reg) ^ y_reg ^ rk_q;
                    rnd_next = rnd_reg + 1'b1;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_y_next     = y_reg;
                    out_x_next     = x_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // configuration; a key write (re)starts the schedule from the new key
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_KEY_LOW:
                begin
                    key_low_next = cfg_data;
                    ka_next      = cfg_data;
                    kb_next      = key_high_reg;
                    kidx_next    = '0;
                    state_next   = ST_EXPAND;
                end
                CFG_KEY_HIGH:
                begin
                    key_high_next = cfg_data;
                    ka_next       = key_low_reg;
                    kb_next       = cfg_data;
                    kidx_next     = '0;
                    state_next    = ST_EXPAND;
                end
                CFG_ROUND_COUNT:
                begin
                    round_count_next = cfg_data[RND_BITS-1:0];
                end
                default:
                begin
                    // unmapped index: ignored
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_EXPAND;
            key_low_reg     <= '0;
            key_high_reg    <= '0;
            round_count_reg <= ROUNDS_MAX;
            ka_reg          <= '0;
            kb_reg          <= '0;
            kidx_reg        <= '0;
            rnd_reg         <= '0;
            lim_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            key_low_reg     <= key_low_next;
            key_high_reg    <= key_high_next;
            round_count_reg <= round_count_next;
            ka_reg          <= ka_next;
            kb_reg          <= kb_next;
            kidx_reg        <= kidx_next;
            rnd_reg         <= rnd_next;
            lim_reg         <= lim_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        y_reg     <= y_next;
        x_reg     <= x_next;
        out_y_reg <= out_y_next;
        out_x_reg <= out_x_next;
    end

    always_ff @(posedge clk)
    begin
        if (ks_we)
        begin
            key_mem[kidx_reg] <= ka_reg;
        end
        rk_q <= key_mem[rk_addr];
    end

endmodule
